[sv/evad_pkg.sv]
// ----------------------------------------------------------------------------
// evad_pkg
// Shared types and constants of the energy voice activity detector.
// ----------------------------------------------------------------------------
`default_nettype none

package evad_pkg;

   localparam int unsigned EVAD_MAX_FRAME    = 4096;
   localparam int unsigned SAMPLE_W          = 16;
   localparam int unsigned FRAME_LEN_W       = 13;
   localparam int unsigned THRESHOLD_W       = 16;
   localparam int unsigned SILENT_NEEDED_W   = 10;
   localparam int unsigned LEVEL_W           = 28;
   localparam int unsigned RUN_W             = 16;
   localparam int unsigned POSITION_W        = 40;
   localparam int unsigned CSR_INDEX_W       = 2;
   localparam int unsigned CSR_DATA_W        = 16;

   localparam logic [FRAME_LEN_W-1:0]     FRAME_LEN_RESET     = 13'd1600;
   localparam logic [THRESHOLD_W-1:0]     THRESHOLD_RESET     = 16'd655;
   localparam logic [SILENT_NEEDED_W-1:0] SILENT_NEEDED_RESET = 10'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_LENGTH     = 2'd0,
      CSR_ENERGY_THRESHOLD = 2'd1,
      CSR_SILENT_FRAMES    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [FRAME_LEN_W-1:0]     frame_length;
      logic [THRESHOLD_W-1:0]     energy_threshold;
      logic [SILENT_NEEDED_W-1:0] silent_frames_needed;
   } evad_cfg_type;

   typedef struct packed {
      logic                  frame_is_speech;
      logic                  speaking;
      logic                  speech_started;
      logic                  speech_ended;
      logic [POSITION_W-1:0] speech_start_sample;
      logic [POSITION_W-1:0] last_speech_sample;
      logic [LEVEL_W-1:0]    frame_level_sum;
   } evad_result_type;

endpackage

`default_nettype wire

[sv/evad_req_if.sv]
// ----------------------------------------------------------------------------
// evad_req_if
// Sample channel: valid, ready and one signed pcm sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface evad_req_if;
   import evad_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

[sv/evad_rsp_if.sv]
// ----------------------------------------------------------------------------
// evad_rsp_if
// Frame result channel: valid, ready and the per-frame decision.
// ----------------------------------------------------------------------------
`default_nettype none

interface evad_rsp_if;
   import evad_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  frame_is_speech;
   logic                  speaking;
   logic                  speech_started;
   logic                  speech_ended;
   logic [POSITION_W-1:0] speech_start_sample;
   logic [POSITION_W-1:0] last_speech_sample;
   logic [LEVEL_W-1:0]    frame_level_sum;

   modport source (
      output valid, output frame_is_speech, output speaking, output speech_started,
      output speech_ended, output speech_start_sample, output last_speech_sample,
      output frame_level_sum, input ready
   );
   modport sink (
      input valid, input frame_is_speech, input speaking, input speech_started,
      input speech_ended, input speech_start_sample, input last_speech_sample,
      input frame_level_sum, output ready
   );
endinterface

`default_nettype wire

[sv/evad_csr.sv]
// ----------------------------------------------------------------------------
// evad_csr
// Configuration registers: frame length, energy threshold, silent frames.
// ----------------------------------------------------------------------------
`default_nettype none

module evad_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_en,
   input  wire logic [evad_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [evad_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output evad_pkg::evad_cfg_type                cfg
);
   import evad_pkg::*;

   evad_cfg_type cfg_ff;
   evad_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_LENGTH: begin
               cfg_in.frame_length = csr_write_data[FRAME_LEN_W-1:0];
            end
            CSR_ENERGY_THRESHOLD: begin
               cfg_in.energy_threshold = csr_write_data[THRESHOLD_W-1:0];
            end
            CSR_SILENT_FRAMES: begin
               cfg_in.silent_frames_needed = csr_write_data[SILENT_NEEDED_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_length         <= FRAME_LEN_RESET;
         cfg_ff.energy_threshold     <= THRESHOLD_RESET;
         cfg_ff.silent_frames_needed <= SILENT_NEEDED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[sv/evad_core.sv]
// ----------------------------------------------------------------------------
// evad_core
// Frame accumulator and speech state: one sample per step, decision at frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module evad_core #(
   parameter int unsigned MAX_FRAME = evad_pkg::EVAD_MAX_FRAME
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire evad_pkg::evad_cfg_type              cfg,
   input  wire logic                                step,
   input  wire logic signed [evad_pkg::SAMPLE_W-1:0] sample,
   output logic                                     frame_end,
   output evad_pkg::evad_result_type                result
);
   import evad_pkg::*;

   localparam int unsigned POS_W  = $clog2(MAX_FRAME);
   localparam int unsigned CNT_W  = $clog2(MAX_FRAME + 1);
   localparam int unsigned LEN_W  = (CNT_W > FRAME_LEN_W) ? CNT_W : FRAME_LEN_W;
   localparam int unsigned PROD_W = THRESHOLD_W + CNT_W;
   localparam int unsigned CMP_W  = (PROD_W > LEVEL_W) ? PROD_W : LEVEL_W;
   localparam int unsigned MAG_W  = SAMPLE_W + 1;

   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  speaking_ff, speaking_in;
   logic [RUN_W-1:0]      run_ff, run_in;
   logic [POSITION_W-1:0] seen_ff, seen_in;
   logic [POSITION_W-1:0] start_ff, start_in;
   logic [POSITION_W-1:0] last_ff, last_in;

   logic [MAG_W-1:0]      sample_ext;
   logic [MAG_W-1:0]      mag;
   logic [LEVEL_W:0]      level_sum;
   logic [LEVEL_W-1:0]    level_sat;
   logic [CNT_W-1:0]      count;
   logic [LEN_W-1:0]      len_ext;
   logic [CNT_W-1:0]      eff_len;
   logic [PROD_W-1:0]     limit;
   logic                  loud_frame;
   logic [RUN_W-1:0]      run_sat;
   logic                  started;
   logic                  ended;

   always_comb begin
      sample_ext = {sample[SAMPLE_W-1], sample};
      mag        = sample_ext[MAG_W-1] ? (MAG_W'(0) - sample_ext) : sample_ext;
      level_sum  = {1'b0, level_ff} + (LEVEL_W+1)'(mag);
      level_sat  = level_sum[LEVEL_W] ? {LEVEL_W{1'b1}} : level_sum[LEVEL_W-1:0];
      seen_in    = (&seen_ff) ? seen_ff : seen_ff + POSITION_W'(1);
      count      = CNT_W'(pos_ff) + CNT_W'(1);

      // zero length counts as one, long lengths clamp to the frame limit
      len_ext = LEN_W'(cfg.frame_length);
      if (len_ext == '0) begin
         eff_len = CNT_W'(1);
      end else if (len_ext > LEN_W'(MAX_FRAME)) begin
         eff_len = CNT_W'(MAX_FRAME);
      end else begin
         eff_len = CNT_W'(len_ext);
      end
      frame_end = (count >= eff_len);

      limit      = PROD_W'(cfg.energy_threshold) * PROD_W'(count);
      loud_frame = CMP_W'(level_sat) > CMP_W'(limit);
      run_sat    = (&run_ff) ? run_ff : run_ff + RUN_W'(1);

      speaking_in = speaking_ff;
      run_in      = run_ff;
      start_in    = start_ff;
      last_in     = last_ff;
      started     = 1'b0;
      ended       = 1'b0;
      if (frame_end) begin
         level_in = '0;
         pos_in   = '0;
         if (loud_frame) begin
            last_in = seen_in;
            run_in  = '0;
            if (!speaking_ff) begin
               speaking_in = 1'b1;
               started     = 1'b1;
               start_in    = (seen_in >= POSITION_W'(count)) ?
                             seen_in - POSITION_W'(count) : '0;
            end
         end else begin
            run_in = run_sat;
            if (speaking_ff && (run_sat >= RUN_W'(cfg.silent_frames_needed))) begin
               speaking_in = 1'b0;
               ended       = 1'b1;
            end
         end
      end else begin
         level_in = level_sat;
         pos_in   = count[POS_W-1:0];
      end

      result.frame_is_speech     = loud_frame;
      result.speaking            = speaking_in;
      result.speech_started      = started;
      result.speech_ended        = ended;
      result.speech_start_sample = start_in;
      result.last_speech_sample  = last_in;
      result.frame_level_sum     = level_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= '0;
         pos_ff      <= '0;
         speaking_ff <= 1'b0;
         run_ff      <= '0;
         seen_ff     <= '0;
         start_ff    <= '0;
         last_ff     <= '0;
      end else if (step) begin
         level_ff    <= level_in;
         pos_ff      <= pos_in;
         speaking_ff <= speaking_in;
         run_ff      <= run_in;
         seen_ff     <= seen_in;
         start_ff    <= start_in;
         last_ff     <= last_in;
      end
   end

endmodule

`default_nettype wire

[sv/energy_voice_activity_detector.sv]
// a sample passes the sample register, then the result register, to rsp_chan
// throughput: 1 sample per cycle while the result sink keeps up, set by the single accumulate-and-decide stage
// one result transfer per frame, none for samples inside a frame
// reset: synchronous, clears the frame sum, counters and speech state,
// loads frame_length 1600, energy_threshold 655, silent_frames_needed 1
// ----------------------------------------------------------------------------
// energy_voice_activity_detector
// Energy based voice activity detector with a sample register, a decision
// stage and a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module energy_voice_activity_detector #(
   parameter int unsigned MAX_FRAME = evad_pkg::EVAD_MAX_FRAME
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   evad_req_if.sink                              req_chan,
   evad_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_write_en,
   input  wire logic [evad_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [evad_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import evad_pkg::*;

   evad_cfg_type               cfg;
   evad_result_type            result;
   evad_result_type            rsp_data_ff;
   logic                       frame_end;
   logic                       s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       s1_advance;
   logic                       req_xfer;

   evad_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   evad_core #(
      .MAX_FRAME (MAX_FRAME)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (s1_advance),
      .sample    (s1_sample_ff),
      .frame_end (frame_end),
      .result    (result)
   );

   always_comb begin
      s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
      req_chan.ready = !s1_valid_ff || s1_advance;
      req_xfer       = req_chan.valid && req_chan.ready;

      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_advance && frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_sample_ff <= req_chan.sample;
      end
      if (s1_advance && frame_end) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.frame_is_speech     = rsp_data_ff.frame_is_speech;
   assign rsp_chan.speaking            = rsp_data_ff.speaking;
   assign rsp_chan.speech_started      = rsp_data_ff.speech_started;
   assign rsp_chan.speech_ended        = rsp_data_ff.speech_ended;
   assign rsp_chan.speech_start_sample = rsp_data_ff.speech_start_sample;
   assign rsp_chan.last_speech_sample  = rsp_data_ff.last_speech_sample;
   assign rsp_chan.frame_level_sum     = rsp_data_ff.frame_level_sum;

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !rsp_valid_ff))
      else $error("pipeline valid set after reset");

   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without a sample in the decision stage");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && rsp_valid_ff))
      else $error("sample side stalled while the stage could drain");

   a_start_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.speech_started) |->
         (rsp_data_ff.frame_is_speech && rsp_data_ff.speaking))
      else $error("speech start without a speech frame");

   a_end_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.speech_ended) |->
         (!rsp_data_ff.frame_is_speech && !rsp_data_ff.speaking
          && !rsp_data_ff.speech_started))
      else $error("speech end on a speech frame");
`endif

endmodule

`default_nettype wire

[tb/sv/energy_voice_activity_detector_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_test
// Self-checking bench for the energy voice activity detector. Streams pcm
// samples through the request channel under random source and sink idling,
// changes the csr settings between idle phases, predicts every frame decision
// in the bench and compares each result transfer field by field.
// ----------------------------------------------------------------------------

module energy_voice_activity_detector_test;
   import evad_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 600;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned LONG_HOLD    = 200;

   localparam longint unsigned LEVEL_MAX    = (64'd1 << LEVEL_W) - 1;
   localparam longint unsigned RUN_MAX      = (64'd1 << RUN_W) - 1;
   localparam longint unsigned POSITION_MAX = (64'd1 << POSITION_W) - 1;

   // full scale, both signs, alternating bits, zero frames between
   localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [10] = '{
      16'h0000, 16'h0001, 16'h0000, 16'hFFFF, 16'h7FFF,
      16'h8000, 16'h8001, 16'h0000, 16'h5555, 16'hAAAA
   };
   // frame of three at threshold 100: equal sum, one above, two quiet frames
   localparam logic [SAMPLE_W-1:0] BOUNDARY_SAMPLES [14] = '{
      16'd100, 16'd100, 16'd100, 16'd100, 16'hFF9C, 16'd101,
      16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd3, 16'd4
   };

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   evad_req_if req_if ();
   evad_rsp_if rsp_if ();

   energy_voice_activity_detector u_top (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   logic [SAMPLE_W-1:0] pending_samples [$];
   evad_result_type     expected_frames [$];
   int unsigned         mismatch_count = 0;

   bit          send_gaps_on = 1'b0;
   bit          recv_gaps_on = 1'b0;
   bit          hold_wanted = 1'b0;
   bit          hold_done;
   int unsigned send_wait;
   int unsigned stall_left;
   int unsigned hold_left;

   // detector state as seen by the bench
   evad_cfg_type    active_cfg;
   longint unsigned frame_sum;
   longint unsigned frame_fill;
   bit              speech_active;
   longint unsigned quiet_run;
   longint unsigned sample_total;
   longint unsigned speech_start_mark;
   longint unsigned speech_last_mark;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [SAMPLE_W-1:0] draw_sample(int unsigned lo, int unsigned hi);
      logic [SAMPLE_W:0] magnitude;
      magnitude = (SAMPLE_W+1)'($urandom_range(hi, lo));
      if ($urandom_range(0, 1) == 1) begin
         magnitude = 17'h10000 - magnitude;
         return magnitude[SAMPLE_W-1:0];
      end
      return (magnitude > 17'h7FFF) ? 16'h7FFF : magnitude[SAMPLE_W-1:0];
   endfunction

   function automatic void advance_detector(input logic [SAMPLE_W-1:0] raw);
      longint unsigned magnitude;
      longint unsigned frame_len;
      longint unsigned fill;
      evad_result_type frame;
      magnitude = raw[SAMPLE_W-1] ? (64'h10000 - raw) : raw;
      frame_sum = frame_sum + magnitude;
      if (frame_sum > LEVEL_MAX) frame_sum = LEVEL_MAX;
      if (sample_total < POSITION_MAX) sample_total++;
      frame_len = active_cfg.frame_length;
      if (frame_len == 0) frame_len = 1;
      if (frame_len > EVAD_MAX_FRAME) frame_len = EVAD_MAX_FRAME;
      fill = frame_fill + 1;
      if (fill < frame_len) begin
         frame_fill = fill;
         return;
      end
      frame = '0;
      frame.frame_is_speech = frame_sum > active_cfg.energy_threshold * fill;
      if (frame.frame_is_speech) begin
         speech_last_mark = sample_total;
         quiet_run = 0;
         if (!speech_active) begin
            speech_active = 1'b1;
            frame.speech_started = 1'b1;
            speech_start_mark = (sample_total >= fill) ? sample_total - fill : 0;
         end
      end else begin
         if (quiet_run < RUN_MAX) quiet_run++;
         if (speech_active && quiet_run >= active_cfg.silent_frames_needed) begin
            speech_active = 1'b0;
            frame.speech_ended = 1'b1;
         end
      end
      frame.speaking = speech_active;
      frame.speech_start_sample = POSITION_W'(speech_start_mark);
      frame.last_speech_sample = POSITION_W'(speech_last_mark);
      frame.frame_level_sum = LEVEL_W'(frame_sum);
      expected_frames.push_back(frame);
      frame_sum = 0;
      frame_fill = 0;
   endfunction

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // sample source
   always @(posedge clock) begin : sample_driver
      int unsigned gap;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.sample <= '0;
         send_wait <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (send_wait != 0) begin
            send_wait <= send_wait - 1;
            req_if.valid <= 1'b0;
         end else if (pending_samples.size() != 0) begin
            gap = send_gaps_on ? $urandom_range(0, 7) : 0;
            req_if.valid <= 1'b1;
            req_if.sample <= pending_samples.pop_front();
            send_wait <= gap;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result sink, with one long hold-off when asked
   always @(posedge clock) begin : result_sink
      int unsigned gap;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_if.ready <= (hold_left == 1);
      end else if (hold_wanted && !hold_done) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
         rsp_if.ready <= 1'b0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         gap = recv_gaps_on ? $urandom_range(0, 7) : 0;
         stall_left <= gap;
         rsp_if.ready <= (gap == 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= (stall_left == 1);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // csr shadow, prediction on sample transfers, checking on result transfers
   always @(posedge clock) begin : frame_monitor
      evad_result_type wanted;
      if (reset) begin
         active_cfg.frame_length = FRAME_LEN_RESET;
         active_cfg.energy_threshold = THRESHOLD_RESET;
         active_cfg.silent_frames_needed = SILENT_NEEDED_RESET;
         frame_sum = 0;
         frame_fill = 0;
         speech_active = 1'b0;
         quiet_run = 0;
         sample_total = 0;
         speech_start_mark = 0;
         speech_last_mark = 0;
         expected_frames.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_FRAME_LENGTH: begin
                  active_cfg.frame_length = csr_write_data[FRAME_LEN_W-1:0];
               end
               CSR_ENERGY_THRESHOLD: begin
                  active_cfg.energy_threshold = csr_write_data[THRESHOLD_W-1:0];
               end
               CSR_SILENT_FRAMES: begin
                  active_cfg.silent_frames_needed = csr_write_data[SILENT_NEEDED_W-1:0];
               end
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) advance_detector(req_if.sample);
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: frame result with none expected, sum %0d", $time,
                        rsp_if.frame_level_sum);
               mismatch_count++;
            end else begin
               wanted = expected_frames.pop_front();
               check_field("frame_is_speech", wanted.frame_is_speech,
                           rsp_if.frame_is_speech);
               check_field("speaking", wanted.speaking, rsp_if.speaking);
               check_field("speech_started", wanted.speech_started, rsp_if.speech_started);
               check_field("speech_ended", wanted.speech_ended, rsp_if.speech_ended);
               check_field("speech_start_sample", wanted.speech_start_sample,
                           rsp_if.speech_start_sample);
               check_field("last_speech_sample", wanted.last_speech_sample,
                           rsp_if.last_speech_sample);
               check_field("frame_level_sum", wanted.frame_level_sum,
                           rsp_if.frame_level_sum);
            end
         end
      end
   end

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic configure(int unsigned frame_len, int unsigned thr, int unsigned silent_needed);
      write_register(CSR_FRAME_LENGTH, CSR_DATA_W'(frame_len));
      write_register(CSR_ENERGY_THRESHOLD, CSR_DATA_W'(thr));
      write_register(CSR_SILENT_FRAMES, CSR_DATA_W'(silent_needed));
      @(negedge clock);
   endtask

   // all samples sent, all results back, then let a trailing sample retire
   task automatic settle_detector();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_if.valid || expected_frames.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int unsigned random_sent;
      int unsigned burst;
      int unsigned frame_len;
      int unsigned span;
      int unsigned thr;
      int unsigned silent_needed;
      int unsigned level;
      logic [SAMPLE_W-1:0] sample;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset frame length holds a partial frame without a result
      send_gaps_on = 1'b1;
      recv_gaps_on = 1'b1;
      for (int n = 0; n < 30; n++) pending_samples.push_back(draw_sample(600, 1400));
      settle_detector();

      // reset threshold and quiet count: loud frame, quiet frame ends speech
      write_register(CSR_FRAME_LENGTH, CSR_DATA_W'(40));
      @(negedge clock);
      for (int n = 0; n < 10; n++) pending_samples.push_back(draw_sample(600, 1400));
      for (int n = 0; n < 40; n++) pending_samples.push_back(draw_sample(0, 600));
      for (int n = 0; n < 40; n++) pending_samples.push_back(draw_sample(600, 1400));
      for (int n = 0; n < 40; n++) pending_samples.push_back(draw_sample(0, 600));
      settle_detector();

      // zero frame length acts as one, zero quiet frames ends speech at once
      configure(0, 0, 0);
      foreach (EDGE_SAMPLES[n]) pending_samples.push_back(EDGE_SAMPLES[n]);
      settle_detector();

      configure(3, 100, 2);
      foreach (BOUNDARY_SAMPLES[n]) pending_samples.push_back(BOUNDARY_SAMPLES[n]);
      settle_detector();

      // frame length shortened below the samples already in the frame
      configure(20, 50, 1);
      for (int n = 0; n < 13; n++) pending_samples.push_back(draw_sample(0, 200));
      settle_detector();
      write_register(CSR_FRAME_LENGTH, CSR_DATA_W'(5));
      @(negedge clock);
      for (int n = 0; n < 7; n++) pending_samples.push_back(draw_sample(0, 200));
      settle_detector();

      // full scale frames: sum equal to the limit, then above it
      send_gaps_on = 1'b0;
      recv_gaps_on = 1'b0;
      configure(4, 32768, 0);
      for (int n = 0; n < 8; n++) pending_samples.push_back(16'h8000);
      settle_detector();
      configure(4, 32767, 1023);
      for (int n = 0; n < 8; n++) pending_samples.push_back(16'h8000);
      settle_detector();

      // sink held off while the source keeps offering
      configure(1, 500, 2);
      hold_wanted = 1'b1;
      for (int n = 0; n < 60; n++) pending_samples.push_back(draw_sample(0, 1500));
      settle_detector();

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: frame_len = 0;
            1: frame_len = $urandom_range(17, 96);
            default: frame_len = $urandom_range(1, 16);
         endcase
         case ($urandom_range(0, 9))
            0: thr = 0;
            1: thr = 65535;
            2: thr = 32768;
            default: thr = $urandom_range(1, 3000);
         endcase
         silent_needed = ($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(0, 4);
         configure(frame_len, thr, silent_needed);
         send_gaps_on = ($urandom_range(0, 3) != 0);
         recv_gaps_on = ($urandom_range(0, 3) != 0);
         burst = $urandom_range(20, 80);
         span = (frame_len == 0) ? 1 : frame_len;
         level = 0;
         for (int n = 0; n < burst; n++) begin
            // loudness redrawn per frame so decisions swing both ways
            if (n % span == 0) begin
               level = $urandom_range(0, (4 * thr + 16 > 32768) ? 32768 : 4 * thr + 16);
            end
            if ($urandom_range(0, 15) == 0) sample = SAMPLE_W'($urandom_range(0, 16'hFFFF));
            else sample = draw_sample(0, level);
            pending_samples.push_back(sample);
         end
         random_sent += burst;
         settle_detector();
      end

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
